// File: rtl/b2da_pkg.sv
// Shared types and constants of the binary to decimal ASCII converter.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package b2da_pkg;

   localparam int ValueWidth       = 32;
   localparam int CountWidth       = 4;
   localparam int DigitWidth       = 6;
   localparam int BcdWidth         = 4;
   localparam int DefaultMaxDigits = 10;
   localparam int ReqDataWidth     = 40;   // 36 payload bits padded to whole bytes
   localparam int RspDataWidth     = 8;
   localparam int ShiftCntWidth    = 5;

   localparam logic [ShiftCntWidth-1:0] LastShift  = 5'(ValueWidth - 1);
   localparam logic [DigitWidth-1:0]    AsciiZero  = 6'd48;
   localparam logic [BcdWidth-1:0]      BcdAddLim  = 4'd5;
   localparam logic [BcdWidth-1:0]      BcdAddCorr = 4'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture a new value and count
      logic shift;   // one shift-add-3 step
      logic pop;     // current digit has been taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_zero; // incoming transaction asks for no digits
      logic last;    // digit on the output is the final one
   } status_type;

endpackage

`default_nettype wire

// File: rtl/b2da_ctrl.sv
// Controller of the converter: idle / convert / emit sequencing.
// Depends on b2da_pkg for command and status types.
`default_nettype none

module b2da_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire b2da_pkg::status_type status,
   output b2da_pkg::cmd_type         cmd
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StConv = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [b2da_pkg::ShiftCntWidth-1:0] shift_cnt_ff, shift_cnt_in;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StEmit);

   always_comb begin
      state_in     = state_ff;
      shift_cnt_in = shift_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         StIdle: begin
            shift_cnt_in = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (!status.in_zero) begin
                  state_in = StConv;
               end
            end
         end
         StConv: begin
            cmd.shift    = 1'b1;
            shift_cnt_in = shift_cnt_ff + 1'b1;
            if (shift_cnt_ff == b2da_pkg::LastShift) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (rsp_tready) begin
               cmd.pop = 1'b1;
               if (status.last) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         shift_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         shift_cnt_ff <= shift_cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/b2da_dpath.sv
// Datapath of the converter: double-dabble shift register, digit counter
// and output digit select. Depends on b2da_pkg.
`default_nettype none

module b2da_dpath #(
   parameter int MAX_DIGITS = b2da_pkg::DefaultMaxDigits
) (
   input  wire logic                              clock,
   input  wire logic [b2da_pkg::ReqDataWidth-1:0] req_tdata,
   input  wire b2da_pkg::cmd_type                 cmd,
   output b2da_pkg::status_type                   status,
   output logic      [b2da_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam logic [b2da_pkg::CountWidth-1:0] MaxCount = b2da_pkg::CountWidth'(MAX_DIGITS);

   logic [b2da_pkg::ValueWidth-1:0]                 bin_ff, bin_in;
   logic [MAX_DIGITS-1:0][b2da_pkg::BcdWidth-1:0]   bcd_ff, bcd_in;
   logic [MAX_DIGITS-1:0][b2da_pkg::BcdWidth-1:0]   bcd_adj;
   logic [MAX_DIGITS*b2da_pkg::BcdWidth-1:0]        adj_flat;
   logic [b2da_pkg::CountWidth-1:0]                 remain_ff, remain_in;
   logic [b2da_pkg::ValueWidth-1:0]                 in_value;
   logic [b2da_pkg::CountWidth-1:0]                 in_count, in_clamped, sel;
   logic [b2da_pkg::BcdWidth-1:0]                   digit;

   assign in_value   = req_tdata[b2da_pkg::ValueWidth-1:0];
   assign in_count   = req_tdata[b2da_pkg::ValueWidth +: b2da_pkg::CountWidth];
   assign in_clamped = (in_count > MaxCount) ? MaxCount : in_count;

   // add 3 to every digit of 5 or more before the doubling shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         bcd_adj[d] = (bcd_ff[d] >= b2da_pkg::BcdAddLim) ?
                      bcd_ff[d] + b2da_pkg::BcdAddCorr : bcd_ff[d];
      end
   end

   assign adj_flat = bcd_adj;

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      remain_in = remain_ff;
      if (cmd.load) begin
         bin_in    = in_value;
         bcd_in    = '0;
         remain_in = in_clamped;
      end else if (cmd.shift) begin
         // top digit's carry bit falls off: keeps the value modulo 10^MAX_DIGITS
         bcd_in = {adj_flat[MAX_DIGITS*b2da_pkg::BcdWidth-2:0],
                   bin_ff[b2da_pkg::ValueWidth-1]};
         bin_in = {bin_ff[b2da_pkg::ValueWidth-2:0], 1'b0};
      end else if (cmd.pop) begin
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      remain_ff <= remain_in;
   end

   // most significant remaining digit goes out first
   assign sel = remain_ff - 1'b1;

   always_comb begin
      digit = '0;
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (sel == b2da_pkg::CountWidth'(d)) begin
            digit = bcd_ff[d];
         end
      end
   end

   assign rsp_tdata = b2da_pkg::RspDataWidth'(
                         b2da_pkg::DigitWidth'(digit) + b2da_pkg::AsciiZero);
   assign rsp_tlast = (remain_ff == b2da_pkg::CountWidth'(1));

   assign status.in_zero = (in_count == '0);
   assign status.last    = rsp_tlast;

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: 32-bit value in, N ASCII digits out.
// Sequence: a request is accepted, the double-dabble shift steps run over
// every bit of the value, then one digit goes out per cycle while rsp_tready
// is high (N = clamped digit count). Transactions are handled one at a
// time; a count of zero is accepted and gives no output.
// Reset: synchronous, active high; clears the controller only.
`default_nettype none

module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = b2da_pkg::DefaultMaxDigits
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [31:0] value, [35:32] digit_count, [39:36] zero
   input  wire logic [b2da_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [5:0] ascii_digit, [7:6] zero
   output logic      [b2da_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                                   rsp_tlast
);

   b2da_pkg::cmd_type    cmd;
   b2da_pkg::status_type status;

   b2da_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   b2da_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // input and output sides never active together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while output valid");

   // a nonzero-count transaction starts a conversion
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       req_tdata[b2da_pkg::ValueWidth +: b2da_pkg::CountWidth] != '0)
      |=> !req_tready)
      else $error("converter did not start");

   // the final digit ends the run
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("output continued after last digit");

   // every emitted character is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= b2da_pkg::RspDataWidth'(48) &&
                      rsp_tdata <= b2da_pkg::RspDataWidth'(57)))
      else $error("non-decimal character emitted");

endmodule

`default_nettype wire
